@@ rtl/rbf_pkg.sv @@
// shared constants and types for the rgb 3x3 box filter
package rbf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int CMP_W     = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;
    localparam int CFG_W     = (WIDTH_W > HEIGHT_W) ? WIDTH_W : HEIGHT_W;

    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int PIX_W     = CHAN_W * NUM_CHAN;
    localparam int WIN_TAPS  = 9;
    localparam int SUM_W     = 12;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 16;

    // sum / 9 as (sum * 7282) >> 16, exact for sums up to 9 * 255
    localparam int RECIP_W     = 13;
    localparam int RECIP_9     = 7282;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [CMP_W-1:0]    MIN_DIM      = CMP_W'(3);
    localparam logic [CMP_W-1:0]    MAX_DIM      = CMP_W'(MAX_WIDTH);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [WIN_TAPS-1:0][CHAN_W-1:0] chan_win_t;

endpackage

@@ rtl/rbf_line_buf.sv @@
// one line buffer: single write port, registered read port, read-first
module rbf_line_buf
    import rbf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [PIX_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rbf_lane.sv @@
// one color channel: nine-tap sum, then divide by nine
module rbf_lane
    import rbf_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  chan_win_t         taps,
    output logic [CHAN_W-1:0] mean
);

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] mean_reg;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(taps[i]);
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP_9);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            mean_reg <= prod[RECIP_SHIFT +: CHAN_W];
        end
    end

    assign mean = mean_reg;

endmodule

@@ rtl/rgb_box_filter_3x3.sv @@
// rgb 3x3 box filter: line buffers, window, three channel lanes, output merge
// a result is registered through stage 1, stage 2 and the output stage after the beat that completes its window
// throughput: one pixel per cycle; the whole pipeline stalls while m_axis is held
// border pixels produce no output beat; tlast marks the last interior pixel
// reset (async, rst_n low): counters, window and valids clear, width 640, height 480
// line buffers are not cleared; an entry read before it is written only reaches border windows, which produce no beat
module rgb_box_filter_3x3
    import rbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // mean_red, mean_green, mean_blue,
                                                  // centre_column, centre_row, zero pad
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [ADDR_W-1:0]   col_reg;
    logic [ADDR_W-1:0]   col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;

    logic                adv;
    logic                accept;
    logic [CMP_W-1:0]    width_eff;
    logic [CMP_W-1:0]    width_ext;
    logic [HEIGHT_W-1:0] height_eff;
    logic [CMP_W-1:0]    col_inc;
    logic [ROW_W:0]      row_inc;
    logic                row_end;
    logic                frame_end;
    logic [PIX_W-1:0]    pix_in;

    logic                s1_valid_reg;
    logic                s1_interior_reg;
    logic                s1_last_reg;
    logic [ADDR_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [PIX_W-1:0]    up_data;
    logic [PIX_W-1:0]    mid_data;

    logic [PIX_W-1:0]    win_reg [6];

    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic [COL_W-1:0]    s2_col_reg;
    logic [ROW_W-1:0]    s2_row_reg;

    logic                out_valid_reg;
    logic                out_last_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;

    logic [PIX_W-1:0]    nb [WIN_TAPS];
    chan_win_t           lane_taps [NUM_CHAN];
    logic [CHAN_W-1:0]   lane_mean [NUM_CHAN];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // pixel held red high, blue low
    assign pix_in = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective frame size and position counters
    always_comb
    begin
        width_ext = CMP_W'(width_reg);
        if (width_ext < MIN_DIM)
        begin
            width_eff = MIN_DIM;
        end
        else if (width_ext > MAX_DIM)
        begin
            width_eff = MAX_DIM;
        end
        else
        begin
            width_eff = width_ext;
        end
        height_eff = (height_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_reg;

        col_inc   = CMP_W'(col_reg) + CMP_W'(1);
        row_inc   = {1'b0, row_reg} + (ROW_W+1)'(1);
        row_end   = col_inc >= width_eff;
        frame_end = row_end && (row_inc >= {1'b0, height_eff});

        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[ADDR_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line buffers: middle is rewritten on accept, upper takes the old middle when stage 1 advances
    rbf_line_buf u_mid_buf (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pix_in),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_data)
    );

    rbf_line_buf u_up_buf (
        .clk   (clk),
        .we    (s1_valid_reg && adv),
        .waddr (s1_col_reg),
        .wdata (mid_data),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_data)
    );

    // stage 1: pixel and position beside the buffer reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_interior_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= ADDR_W'(2));
            s1_last_reg     <= frame_end;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_pix_reg      <= pix_in;
        end
    end

    // 3x3 neighborhood, oldest column first, top row first
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            nb[i] = win_reg[i];
        end
        nb[6] = up_data;
        nb[7] = mid_data;
        nb[8] = s1_pix_reg;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                lane_taps[k][i] = nb[i][(NUM_CHAN-1-k)*CHAN_W +: CHAN_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg && adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_data;
            win_reg[4] <= mid_data;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // channel lanes: sum in stage 2, mean in the output stage
    for (genvar gi = 0; gi < NUM_CHAN; gi++)
    begin : g_lane
        rbf_lane u_lane (
            .clk  (clk),
            .en   (adv),
            .taps (lane_taps[gi]),
            .mean (lane_mean[gi])
        );
    end

    // stage 2 and output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= s1_valid_reg && s1_interior_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_col_reg   <= COL_W'(s1_col_reg - ADDR_W'(1));
            s2_row_reg   <= s1_row_reg - ROW_W'(1);
            out_last_reg <= s2_last_reg;
            out_col_reg  <= s2_col_reg;
            out_row_reg  <= s2_row_reg;
        end
    end

    // merge lanes and position into the output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - NUM_CHAN*CHAN_W - COL_W - ROW_W)'(0),
        out_row_reg,
        out_col_reg,
        lane_mean[2],
        lane_mean[1],
        lane_mean[0]
    };

endmodule

@@ test/tb.sv @@
// testbench for rgb_box_filter_3x3: window mean predictor, stream drivers and idle phases
`timescale 1ns / 1ps

import rbf_pkg::*;

typedef struct packed {
    logic        last;
    logic [15:0] row;
    logic [10:0] col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
} box_mean_t;

class mean_scoreboard;
    logic [PIX_W-1:0] upper_row [MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [MAX_WIDTH];
    // [0..2] column c-2 top..bottom, [3..5] column c-1 top..bottom
    logic [PIX_W-1:0] window [6];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      width_reg;
    int unsigned      height_reg;
    box_mean_t        expected_means [$];
    int               errors;

    function new();
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (window[i])
            window[i] = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        width_reg  = 640;
        height_reg = 480;
        errors     = 0;
    endfunction

    function int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function int unsigned eff_height();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, int unsigned value);
        if (idx == REG_WIDTH)
            width_reg = value & 'hFFF;
        else
            height_reg = value & 'hFFFF;
    endfunction

    // beats still to go before the row and column counters are back at zero
    function int unsigned to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned row_left;
        w = eff_width();
        h = eff_height();
        if (col_cnt == 0 && row_cnt == 0)
            return 0;
        row_left = (col_cnt >= w) ? 1 : w - col_cnt;
        if (row_cnt + 1 >= h)
            return row_left;
        return row_left + (h - 1 - row_cnt) * w;
    endfunction

    function logic [7:0] mean_of(logic [PIX_W-1:0] taps [9], int lane);
        int unsigned sum;
        sum = 0;
        foreach (taps[i])
            sum += taps[i][lane * CHAN_W +: CHAN_W];
        return 8'(sum / 9);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] taps [9];
        box_mean_t        m;
        w   = eff_width();
        h   = eff_height();
        c   = col_cnt;
        r   = row_cnt;
        up  = '0;
        mid = '0;
        if (c < MAX_WIDTH)
        begin
            up            = upper_row[c];
            mid           = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = pix;
        end
        if (r >= 2 && c >= 2)
        begin
            for (int i = 0; i < 6; i++)
                taps[i] = window[i];
            taps[6] = up;
            taps[7] = mid;
            taps[8] = pix;
            m.red   = mean_of(taps, 0);
            m.green = mean_of(taps, 1);
            m.blue  = mean_of(taps, 2);
            m.col   = 11'(c - 1);
            m.row   = 16'(r - 1);
            m.last  = (c + 1 >= w) && (r + 1 >= h);
            expected_means.push_back(m);
        end
        for (int i = 0; i < 3; i++)
            window[i] = window[i + 3];
        window[3] = up;
        window[4] = mid;
        window[5] = pix;
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 'hFFFF);
        end
        else
            col_cnt = (c + 1) & 'h1FFF;
    endfunction

    task report(string msg);
        errors++;
        // keep the log short on a badly broken build
        if (errors <= 40)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_mean(logic [OUT_TDATA_W-1:0] data, logic last);
        box_mean_t m;
        if (expected_means.size() == 0)
        begin
            report($sformatf("output beat %h with no mean pending", data));
            return;
        end
        m = expected_means.pop_front();
        check_field("mean_red", data[7:0], m.red);
        check_field("mean_green", data[15:8], m.green);
        check_field("mean_blue", data[23:16], m.blue);
        check_field("centre_column", data[34:24], m.col);
        check_field("centre_row", data[50:35], m.row);
        check_field("tlast", last, m.last);
    endtask
endclass

module tb;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_PIXELS = 280;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // pixel_red, pixel_green, pixel_blue
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // mean_red, mean_green, mean_blue,
                                                 // centre_column, centre_row, zero pad
    logic                   m_axis_tlast;
    logic                   cfg_we        = 1'b0;
    logic                   cfg_index     = REG_WIDTH;
    logic [CFG_W-1:0]       cfg_data      = '0;

    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned pixels_sent    = 0;
    bit          extreme_pixels = 1'b0;

    mean_scoreboard sb = new();

    rgb_box_filter_3x3 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // output side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served   <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mean(m_axis_tdata, m_axis_tlast);
    end

    function automatic logic [7:0] rail();
        return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pixel(s_axis_tdata);
        pixels_sent++;
    endtask

    task automatic send_random(int unsigned count);
        repeat (count)
        begin
            if (extreme_pixels)
                send_pixel(rail(), rail(), rail());
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // drop valid, wait out every pending mean and the pipeline behind it
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a negative value leaves that register alone
    task automatic write_regs(int width_val, int height_val);
        if (width_val >= 0)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_WIDTH;
            cfg_data  <= CFG_W'(width_val);
            @(posedge clk);
            sb.write_reg(REG_WIDTH, width_val);
        end
        if (height_val >= 0)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_HEIGHT;
            cfg_data  <= CFG_W'(height_val);
            @(posedge clk);
            sb.write_reg(REG_HEIGHT, height_val);
        end
        cfg_we <= 1'b0;
    endtask

    // run to the next frame boundary; a long remainder is cut short at the current row, or at row 2 if that is later
    task automatic finish_frame();
        if (sb.to_frame_end() > 64)
        begin
            settle();
            write_regs(-1, $urandom_range(sb.row_cnt + 1));
        end
        send_random(sb.to_frame_end());
        settle();
    endtask

    initial
    begin
        int unsigned phase_start;
        int          width_val;
        int          height_val;
        int unsigned pick;
        int          wait_cycles;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, both registers below range
        write_regs(0, 2);
        // saturated channels, then a sum that truncates down
        for (int i = 0; i < 9; i++)
            send_pixel(8'hFF, 8'h00, (i == 8) ? 8'hFE : 8'hFF);
        for (int i = 0; i < 9; i++)
            send_pixel(8'(i * 31), 8'(255 - i), 8'h80);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase

            if (phase == 0)
            begin
                // width clamps to the line buffer depth, then narrows mid-row
                write_regs(16'hFFFF, 3);
                send_random(40);
                settle();
                // tallest height, later cut short mid-frame; the output stalls for a long stretch
                write_regs(5, 16'hFFFF);
                hold_asked++;
                send_random(4 * 5);
                settle();
            end

            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS)
            begin
                extreme_pixels = ($urandom_range(9) == 0);
                if ($urandom_range(4) == 0)
                begin
                    // mid-frame change: any height, or a width no wider than the current one
                    settle();
                    if ($urandom_range(1))
                    begin
                        pick = $urandom_range(3);
                        if (pick == 0)
                            height_val = 16'hFFFF;
                        else if (pick == 1)
                            height_val = $urandom_range(2);
                        else
                            height_val = $urandom_range(16'hFFFF);
                        write_regs(-1, height_val);
                    end
                    else
                    begin
                        width_val = $urandom_range(sb.eff_width()) | ($urandom_range(15) << 12);
                        write_regs(width_val, -1);
                    end
                    send_random($urandom_range(1, 3 * sb.eff_width()));
                end
                else
                begin
                    finish_frame();
                    pick = $urandom_range(19);
                    if (pick < 2)
                        width_val = $urandom_range(2);
                    else if (pick < 4)
                        width_val = $urandom_range(13, 40);
                    else
                        width_val = $urandom_range(3, 12);
                    // upper data bits fall outside the width register
                    if ($urandom_range(3) == 0)
                        width_val |= $urandom_range(15) << 12;
                    height_val = ($urandom_range(6) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
                    write_regs(width_val, height_val);
                    send_random($urandom_range(1, 2) * sb.eff_width() * sb.eff_height());
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 5000 && sb.expected_means.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_means.size() != 0)
            sb.report($sformatf("%0d means never came out", sb.expected_means.size()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
